@@ sv/sts_pkg.sv @@
`default_nettype none

package sts_pkg;

  localparam int FRAC_BITS     = 28;
  localparam int MAX_TERMS_DEF = 10;

  localparam int AW    = 32;
  localparam int CW    = 4;
  localparam int OW    = 48;
  localparam int IN_TW = 40;

  localparam int CHUNK = 32;

  localparam int MW   = 32;
  localparam int M2W  = 64;
  localparam int RB   = 84;
  localparam int RW   = 82;
  localparam int YSH  = 64;
  localparam int YW   = 80;
  localparam int TF   = 76;
  localparam int TW   = 85;
  localparam int RSH  = TF - FRAC_BITS;
  localparam int MAGW = TW - RSH + 1;

  typedef struct packed {
    logic                 neg;
    logic [CW-1:0]        cnt;
    logic signed [OW-1:0] sum;
  } sts_ctl_t;

endpackage

`default_nettype wire

@@ sv/sts_mul.sv @@
`default_nettype none

module sts_mul #(
  parameter int AWID = 64,
  parameter int BWID = 64,
  parameter int SW   = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [AWID-1:0]      a,
  input  wire logic [BWID-1:0]      b,
  input  wire logic [SW-1:0]        in_side,
  output logic                      out_valid,
  output logic [AWID+BWID-1:0]      prod,
  output logic [SW-1:0]             out_side
);
  import sts_pkg::*;

  localparam int NA  = (AWID + CHUNK - 1) / CHUNK;
  localparam int NB  = (BWID + CHUNK - 1) / CHUNK;
  localparam int NS  = NA * NB;
  localparam int PW  = AWID + BWID;
  localparam int APW = NA * CHUNK;
  localparam int BPW = NB * CHUNK;

  logic           vld [NS];
  logic [APW-1:0] a_q [NS];
  logic [BPW-1:0] b_q [NS];
  logic [PW-1:0]  acc [NS];
  logic [SW-1:0]  sd  [NS];

  logic           vld_in [NS];
  logic [APW-1:0] a_in   [NS];
  logic [BPW-1:0] b_in   [NS];
  logic [PW-1:0]  acc_in [NS];
  logic [SW-1:0]  sd_in  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int I = s / NB;
    localparam int J = s % NB;
    logic [2*CHUNK-1:0] pp;
    logic [PW-1:0]      acc_next;

    if (s == 0) begin : g_first
      assign vld_in[s] = in_valid;
      assign a_in[s]   = APW'(a);
      assign b_in[s]   = BPW'(b);
      assign acc_in[s] = '0;
      assign sd_in[s]  = in_side;
    end else begin : g_rest
      assign vld_in[s] = vld[s-1];
      assign a_in[s]   = a_q[s-1];
      assign b_in[s]   = b_q[s-1];
      assign acc_in[s] = acc[s-1];
      assign sd_in[s]  = sd[s-1];
    end

    assign pp = (2*CHUNK)'(a_in[s][I*CHUNK +: CHUNK]) *
                (2*CHUNK)'(b_in[s][J*CHUNK +: CHUNK]);
    assign acc_next = acc_in[s] + (PW'(pp) << (CHUNK * (I + J)));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_q[s] <= a_in[s];
        b_q[s] <= b_in[s];
        acc[s] <= acc_next;
        sd[s]  <= sd_in[s];
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign prod      = acc[NS-1];
  assign out_side  = sd[NS-1];

endmodule

`default_nettype wire

@@ sv/sts_term.sv @@
`default_nettype none

module sts_term #(
  parameter int K = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [sts_pkg::TW-1:0]  in_t,
  input  wire logic [sts_pkg::M2W-1:0] in_m2,
  input  wire sts_pkg::sts_ctl_t in_ctl,
  output logic                   out_valid,
  output logic [sts_pkg::TW-1:0]  out_t,
  output logic [sts_pkg::M2W-1:0] out_m2,
  output sts_pkg::sts_ctl_t       out_ctl
);
  import sts_pkg::*;

  localparam int CTLW = $bits(sts_ctl_t);
  localparam int C    = (2 * K - 2) * (2 * K - 1);
  localparam logic [RB:0]   RONE = (RB+1)'(1) << RB;
  localparam logic [RW-1:0] RK   = RW'(RONE / (RB+1)'(C));
  localparam logic          NEG_K = ((K % 2) == 0);

  localparam int S1W = TW + M2W + CTLW;
  localparam int S2W = M2W + CTLW;

  logic                 v1;
  logic [M2W+RW-1:0]    p1;
  logic [S1W-1:0]       s1;
  logic [TW-1:0]        t1;
  logic [M2W-1:0]       m21;
  sts_ctl_t             ctl1;

  sts_mul #(.AWID(M2W), .BWID(RW), .SW(S1W)) u_ymul (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .a        (in_m2),
    .b        (RK),
    .in_side  ({in_t, in_m2, in_ctl}),
    .out_valid(v1),
    .prod     (p1),
    .out_side (s1)
  );

  assign {t1, m21, ctl1} = s1;

  logic              v2;
  logic [TW+YW-1:0]  p2;
  logic [S2W-1:0]    s2;
  logic [M2W-1:0]    m22;
  sts_ctl_t          ctl2;
  logic [TW-1:0]     t_new;
  logic [MAGW-1:0]   mag_next;

  sts_mul #(.AWID(TW), .BWID(YW), .SW(S2W)) u_tmul (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v1),
    .a        (t1),
    .b        (p1[YSH +: YW]),
    .in_side  ({m21, ctl1}),
    .out_valid(v2),
    .prod     (p2),
    .out_side (s2)
  );

  assign {m22, ctl2} = s2;
  assign t_new    = p2[TF +: TW];
  assign mag_next = MAGW'(t_new[TW-1:RSH]) + MAGW'(t_new[RSH-1]);

  logic            v3;
  logic [TW-1:0]   t3;
  logic [M2W-1:0]  m23;
  sts_ctl_t        ctl3;
  logic [MAGW-1:0] mag3;
  sts_ctl_t        ctl_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_comb begin
    ctl_next = ctl3;
    if (CW'(K) <= ctl3.cnt) begin
      if (ctl3.neg ^ NEG_K) begin
        ctl_next.sum = ctl3.sum - OW'(mag3);
      end else begin
        ctl_next.sum = ctl3.sum + OW'(mag3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3      <= t_new;
      m23     <= m22;
      ctl3    <= ctl2;
      mag3    <= mag_next;
      out_t   <= t3;
      out_m2  <= m23;
      out_ctl <= ctl_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/sine_taylor_series.sv @@
// Partial Taylor sum of sine in fixed point.
// Input words arrive on s_tvalid/s_tready/s_tdata: the angle is signed Q3.28,
// the term count is clipped to MAX_TERMS, and a count of zero returns zero.
// Result words leave on m_tvalid/m_tready/m_tdata as signed Q19.28 sums.
// Every term after the first is built from the previous one by a multiply
// with x squared over (2k-2)(2k-1), using a 32-bit chunked multiplier in
// which each stage adds one partial product, and is rounded to nearest.
// The pipeline has two front stages, then per term six stages for the ratio,
// nine for the term product and two for rounding and accumulation.
// One word can enter every cycle while the pipeline is not frozen, and results leave in input order.
// Reset empties the pipeline; no word is presented after it until new input.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated.
`default_nettype none

module sine_taylor_series #(
  parameter int MAX_TERMS = sts_pkg::MAX_TERMS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0: angle[31:0], term_count[35:32], zero fill.
  input  wire logic [sts_pkg::IN_TW-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // Fields from bit 0: sine_sum[47:0].
  output logic [sts_pkg::OW-1:0]          m_tdata
);
  import sts_pkg::*;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [AW-1:0] angle;
  logic [CW-1:0] term_count;
  assign angle      = s_tdata[AW-1:0];
  assign term_count = s_tdata[AW +: CW];

  logic          va;
  logic [MW-1:0] ma;
  logic          nega;
  logic [CW-1:0] cnta;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nega <= angle[AW-1];
      ma   <= angle[AW-1] ? MW'(~angle + 1'b1) : MW'(angle);
      cnta <= (term_count > CW'(MAX_TERMS)) ? CW'(MAX_TERMS) : term_count;
    end
  end

  logic           v_s   [MAX_TERMS];
  logic [TW-1:0]  t_s   [MAX_TERMS];
  logic [M2W-1:0] m2_s  [MAX_TERMS];
  sts_ctl_t       ctl_s [MAX_TERMS];

  logic [OW-1:0]  mext;
  logic [M2W-1:0] m2_next;
  sts_ctl_t       ctl_front;

  assign mext    = OW'(ma);
  assign m2_next = M2W'(ma) * M2W'(ma);

  always_comb begin
    ctl_front.neg = nega;
    ctl_front.cnt = cnta;
    if (cnta == '0) begin
      ctl_front.sum = '0;
    end else if (nega) begin
      ctl_front.sum = OW'(0) - mext;
    end else begin
      ctl_front.sum = mext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_s[0]   <= TW'(ma) << RSH;
      m2_s[0]  <= m2_next;
      ctl_s[0] <= ctl_front;
    end
  end

  for (genvar k = 2; k <= MAX_TERMS; k++) begin : g_term
    sts_term #(.K(k)) u_term (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v_s[k-2]),
      .in_t     (t_s[k-2]),
      .in_m2    (m2_s[k-2]),
      .in_ctl   (ctl_s[k-2]),
      .out_valid(v_s[k-1]),
      .out_t    (t_s[k-1]),
      .out_m2   (m2_s[k-1]),
      .out_ctl  (ctl_s[k-1])
    );
  end

  assign m_tvalid = v_s[MAX_TERMS-1];
  assign m_tdata  = ctl_s[MAX_TERMS-1].sum;

  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    (v_s[0] && ctl_s[0].cnt == '0) |-> ctl_s[0].sum == '0)
    else $error("zero term count produced a nonzero first sum");

  a_count_clip: assert property (@(posedge clk) disable iff (rst)
    va |-> cnta <= CW'(MAX_TERMS))
    else $error("term count not clipped to the configured maximum");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(t_s[0]) && $stable(m2_s[0]))
    else $error("front stage changed while the pipeline was stalled");

endmodule

`default_nettype wire
